// ----- hw/rtl/lpqcf_pkg.sv -----
// lpqcf_pkg: shared constants, result kind codes and the control/status structs
// of the log packet queue framer
// no dependencies
package lpqcf_pkg;

    localparam int QUEUE_SLOTS_DEF    = 16;
    localparam int MAX_DATA_BYTES_DEF = 4;
    localparam int INPUT_DATA_FIELDS  = 4;

    localparam logic [7:0] MARKER_RESET = 8'hA6;

    typedef enum logic [1:0] {
        KIND_FRAME    = 2'd0,
        KIND_ACCEPTED = 2'd1,
        KIND_DROPPED  = 2'd2,
        KIND_EMPTY    = 2'd3
    } result_kind_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic enq_store;   // write packet, report accepted
        logic enq_drop;    // report dropped
        logic deq_start;   // read oldest slot, advance read pointer
        logic empty_rsp;   // report nothing to send
        logic emit_code;   // emit code byte of the current group
        logic emit_data;   // emit payload byte
        logic emit_trail;  // emit closing marker
    } lpqcf_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic full;
        logic empty;
        logic run_zero;    // no plain bytes before next marker or end
        logic more;        // payload position below length
        logic left_one;    // last plain byte of this group
        logic more_after;  // another payload byte follows the current one
    } lpqcf_stat_t;

endpackage

// ----- hw/rtl/log_packet_queue_cobs_framer.sv -----
// log_packet_queue_cobs_framer: top level, ring queue of log packets with cobs framing
// instantiates lpqcf_ctrl and lpqcf_dpath; depends on lpqcf_pkg
//
//  channel   handshake             beat
//  -------   ---------             ----
//  command   start, busy           command, log_id, data_count, data_byte_0..3
//  result    result_valid strobe   result_kind, frame_byte, last_of_run
//  config    cfg_we                cfg_wdata (frame marker)
//
// an enqueue is taken in the idle state, its status beat appears the cycle after acceptance
// a transmit first reads the slot, then emits one frame byte a cycle; a frame
// holds payload length + 2 bytes, so 3 to 7; an empty queue gives an empty beat
// the encoder walks the payload byte by byte
// busy is high while a frame is being emitted; results cannot be stalled
// reset clears the pointers, the state machine and loads marker 0xa6; the
// packet memory is not cleared, a slot is only read after it was written
module log_packet_queue_cobs_framer
    import lpqcf_pkg::*;
#(
    parameter int QUEUE_SLOTS    = QUEUE_SLOTS_DEF,
    parameter int MAX_DATA_BYTES = MAX_DATA_BYTES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    // command channel
    input  logic       start,
    output logic       busy,
    input  logic       command,
    input  logic [7:0] log_id,
    input  logic [2:0] data_count,
    input  logic [7:0] data_byte_0,
    input  logic [7:0] data_byte_1,
    input  logic [7:0] data_byte_2,
    input  logic [7:0] data_byte_3,
    // configuration
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    // result channel
    output logic       result_valid,
    output logic [1:0] result_kind,
    output logic [7:0] frame_byte,
    output logic       last_of_run
);

    lpqcf_cmd_t  cmd;   // controller commands
    lpqcf_stat_t stat;  // queue and encoder status

    // sequencer: accept, slot read, code/data/trailer beats
    lpqcf_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .stat    (stat),
        .cmd     (cmd),
        .busy    (busy)
    );

    // ring memory, pointers, marker and the byte-serial encoder
    lpqcf_dpath #(
        .QUEUE_SLOTS    (QUEUE_SLOTS),
        .MAX_DATA_BYTES (MAX_DATA_BYTES)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .log_id       (log_id),
        .data_count   (data_count),
        .data_byte_0  (data_byte_0),
        .data_byte_1  (data_byte_1),
        .data_byte_2  (data_byte_2),
        .data_byte_3  (data_byte_3),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .result_kind  (result_kind),
        .frame_byte   (frame_byte),
        .last_of_run  (last_of_run)
    );

endmodule

// ----- hw/rtl/lpqcf_ctrl.sv -----
// lpqcf_ctrl: controller state machine of the log packet queue framer
// depends on lpqcf_pkg
module lpqcf_ctrl
    import lpqcf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        command,
    input  lpqcf_stat_t stat,
    output lpqcf_cmd_t  cmd,
    output logic        busy
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CODE  = 4'b0010,
        ST_DATA  = 4'b0100,
        ST_TRAIL = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (!command)
                    begin
                        if (stat.full)
                            cmd.enq_drop = 1'b1;
                        else
                            cmd.enq_store = 1'b1;
                    end
                    else if (stat.empty)
                    begin
                        cmd.empty_rsp = 1'b1;
                    end
                    else
                    begin
                        cmd.deq_start = 1'b1;
                        state_next    = ST_CODE;
                    end
                end
            end
            ST_CODE:
            begin
                cmd.emit_code = 1'b1;
                if (!stat.run_zero)
                    state_next = ST_DATA;
                else if (!stat.more)
                    state_next = ST_TRAIL;
            end
            ST_DATA:
            begin
                cmd.emit_data = 1'b1;
                if (stat.left_one)
                    state_next = stat.more_after ? ST_CODE : ST_TRAIL;
            end
            ST_TRAIL:
            begin
                cmd.emit_trail = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// ----- hw/rtl/lpqcf_dpath.sv -----
// lpqcf_dpath: packet ring memory, pointers, marker register and cobs encoder
// datapath with registered result beat; depends on lpqcf_pkg
module lpqcf_dpath
    import lpqcf_pkg::*;
#(
    parameter int QUEUE_SLOTS    = QUEUE_SLOTS_DEF,
    parameter int MAX_DATA_BYTES = MAX_DATA_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic [7:0]  log_id,
    input  logic [2:0]  data_count,
    input  logic [7:0]  data_byte_0,
    input  logic [7:0]  data_byte_1,
    input  logic [7:0]  data_byte_2,
    input  logic [7:0]  data_byte_3,
    input  lpqcf_cmd_t  cmd,
    output lpqcf_stat_t stat,
    output logic        result_valid,
    output logic [1:0]  result_kind,
    output logic [7:0]  frame_byte,
    output logic        last_of_run
);

    localparam int DATA_LIM = (MAX_DATA_BYTES < INPUT_DATA_FIELDS) ?
                              MAX_DATA_BYTES : INPUT_DATA_FIELDS;
    localparam int PAY_MAX  = DATA_LIM + 1;
    localparam int CNT_W    = $clog2(DATA_LIM + 1);
    localparam int P_W      = $clog2(PAY_MAX + 1);
    localparam int PTR_W    = $clog2(QUEUE_SLOTS);

    typedef struct packed {
        logic [CNT_W-1:0]              count;
        logic [7:0]                    id;
        logic [DATA_LIM-1:0][7:0]      data;
    } entry_t;

    entry_t           mem_reg [QUEUE_SLOTS];
    entry_t           rd_entry_reg;
    entry_t           wr_entry;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [7:0]       marker_reg;
    logic [P_W-1:0]   pos_reg, pos_next;
    logic [P_W-1:0]   left_reg, left_next;
    logic [P_W-1:0]   plen;
    logic [P_W-1:0]   run;
    logic             run_stop;
    logic [7:0]       pay [PAY_MAX];
    logic [7:0]       din [INPUT_DATA_FIELDS];
    logic [7:0]       cur_byte;
    logic             valid_reg;
    logic [1:0]       kind_reg;
    logic [7:0]       byte_reg;
    logic             last_reg;

    assign din[0] = data_byte_0;
    assign din[1] = data_byte_1;
    assign din[2] = data_byte_2;
    assign din[3] = data_byte_3;

    // ring pointers wrap at the slot count
    assign wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_SLOTS - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_SLOTS - 1)) ? '0 : rd_ptr_reg + 1'b1;

    assign stat.full  = (wr_ptr_next == rd_ptr_reg);
    assign stat.empty = (wr_ptr_reg == rd_ptr_reg);

    // packet to store, count saturated
    always_comb
    begin
        wr_entry.id    = log_id;
        wr_entry.count = (data_count > 3'(DATA_LIM)) ? CNT_W'(DATA_LIM) : CNT_W'(data_count);
        for (int i = 0; i < DATA_LIM; i++)
            wr_entry.data[i] = din[i];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.enq_store)
            mem_reg[wr_ptr_reg] <= wr_entry;
        if (cmd.deq_start)
            rd_entry_reg <= mem_reg[rd_ptr_reg];
    end

    // payload view of the slot being sent
    always_comb
    begin
        pay[0] = rd_entry_reg.id;
        for (int i = 1; i < PAY_MAX; i++)
            pay[i] = rd_entry_reg.data[i-1];
    end

    assign plen = P_W'(rd_entry_reg.count) + 1'b1;

    // plain bytes from the current position up to the next marker or the end
    always_comb
    begin
        run      = '0;
        run_stop = 1'b0;
        cur_byte = '0;
        for (int i = 0; i < PAY_MAX; i++)
        begin
            if (pos_reg == P_W'(i))
                cur_byte = pay[i];
            if ((P_W'(i) >= pos_reg) && !run_stop)
            begin
                if ((P_W'(i) < plen) && (pay[i] != marker_reg))
                    run = run + 1'b1;
                else
                    run_stop = 1'b1;
            end
        end
    end

    assign stat.run_zero   = (run == '0);
    assign stat.more       = (pos_reg < plen);
    assign stat.left_one   = (left_reg == P_W'(1));
    assign stat.more_after = ((pos_reg + 1'b1) < plen);

    always_comb
    begin
        pos_next  = pos_reg;
        left_next = left_reg;
        if (cmd.deq_start)
        begin
            pos_next = '0;
        end
        else if (cmd.emit_code)
        begin
            left_next = run;
            if (stat.run_zero && stat.more)
                pos_next = pos_reg + 1'b1;
        end
        else if (cmd.emit_data)
        begin
            left_next = left_reg - 1'b1;
            // skip the marker that closes the group
            if (stat.left_one && stat.more_after)
                pos_next = pos_reg + P_W'(2);
            else
                pos_next = pos_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        left_reg <= left_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            marker_reg <= MARKER_RESET;
            valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.enq_store)
                wr_ptr_reg <= wr_ptr_next;
            if (cmd.deq_start)
                rd_ptr_reg <= rd_ptr_next;
            if (cfg_we)
                marker_reg <= cfg_wdata;
            valid_reg <= cmd.enq_store | cmd.enq_drop | cmd.empty_rsp |
                         cmd.emit_code | cmd.emit_data | cmd.emit_trail;
        end
    end

    // result beat register
    always_ff @(posedge clk)
    begin
        kind_reg <= KIND_FRAME;
        byte_reg <= '0;
        last_reg <= 1'b1;
        if (cmd.enq_store)
            kind_reg <= KIND_ACCEPTED;
        else if (cmd.enq_drop)
            kind_reg <= KIND_DROPPED;
        else if (cmd.empty_rsp)
            kind_reg <= KIND_EMPTY;
        else if (cmd.emit_code)
        begin
            byte_reg <= 8'(run) + 8'd1;
            last_reg <= 1'b0;
        end
        else if (cmd.emit_data)
        begin
            byte_reg <= cur_byte;
            last_reg <= 1'b0;
        end
        else if (cmd.emit_trail)
            byte_reg <= marker_reg;
    end

    assign result_valid = valid_reg;
    assign result_kind  = kind_reg;
    assign frame_byte   = byte_reg;
    assign last_of_run  = last_reg;

endmodule

// ----- tb/tb_log_packet_queue_cobs_framer.sv -----
// tb_log_packet_queue_cobs_framer: self-checking bench for the log packet queue framer,
// a scoreboard class predicts status beats and cobs frames, plain tasks drive the block
// depends on lpqcf_pkg and log_packet_queue_cobs_framer
module tb_log_packet_queue_cobs_framer;
    import lpqcf_pkg::*;

    localparam logic CMD_ENQUEUE  = 1'b0;
    localparam logic CMD_TRANSMIT = 1'b1;

    // widest frame: code, id, four data bytes, closing marker
    localparam int FRAME_MAX      = MAX_DATA_BYTES_DEF + 3;
    localparam int QUIET_LIMIT    = 2000;
    localparam int GAP_CAP        = 40;

    // one stored log packet, data length already saturated
    typedef struct packed {
        logic [2:0]      len;
        logic [7:0]      id;
        logic [3:0][7:0] data;
    } packet_t;

    // one result beat as seen on the result channel
    typedef struct packed {
        result_kind_t kind;
        logic [7:0]   value;
        logic         last;
    } beat_t;

    // keeps its own copy of the ring and the marker, turns each accepted
    // command into the beats it should cause and checks them in order
    class cobs_frame_board;
        packet_t    ring[QUEUE_SLOTS_DEF];
        int         head;
        int         tail;
        logic [7:0] marker;
        beat_t      due_beats[$];
        int         errors;

        function new();
            head   = 0;
            tail   = 0;
            marker = MARKER_RESET;
            errors = 0;
        endfunction

        function void set_marker(logic [7:0] v);
            marker = v;
        endfunction

        function int pending();
            return due_beats.size();
        endfunction

        function void push_beat(result_kind_t kind, logic [7:0] value, logic last);
            beat_t b;
            b.kind  = kind;
            b.value = value;
            b.last  = last;
            due_beats.push_back(b);
        endfunction

        function void note_command(logic cmd, logic [7:0] id, logic [2:0] cnt,
                                   logic [3:0][7:0] bytes);
            int         lim;
            int         nxt;
            int         plen;
            int         wr;
            int         code_at;
            int         code;
            logic [7:0] payload[MAX_DATA_BYTES_DEF + 1];
            logic [7:0] frame[FRAME_MAX];
            packet_t    p;

            lim = (MAX_DATA_BYTES_DEF < INPUT_DATA_FIELDS) ? MAX_DATA_BYTES_DEF
                                                            : INPUT_DATA_FIELDS;
            if (cmd == CMD_ENQUEUE)
            begin
                nxt = (tail + 1) % QUEUE_SLOTS_DEF;
                if (nxt == head)
                begin
                    push_beat(KIND_DROPPED, 8'h00, 1'b1);
                    return;
                end
                p.len = (int'(cnt) > lim) ? 3'(lim) : cnt;
                p.id  = id;
                for (int i = 0; i < 4; i++)
                    p.data[i] = (i < int'(p.len)) ? bytes[i] : 8'h00;
                ring[tail] = p;
                tail = nxt;
                push_beat(KIND_ACCEPTED, 8'h00, 1'b1);
                return;
            end
            if (head == tail)
            begin
                push_beat(KIND_EMPTY, 8'h00, 1'b1);
                return;
            end
            p    = ring[head];
            head = (head + 1) % QUEUE_SLOTS_DEF;
            plen = 1 + int'(p.len);
            payload[0] = p.id;
            for (int k = 1; k < plen; k++)
                payload[k] = p.data[k - 1];
            // each marker in the payload closes a group, its place becomes the next code slot
            wr      = 1;
            code_at = 0;
            code    = 1;
            for (int r = 0; r < plen; r++)
            begin
                if (payload[r] == marker)
                begin
                    frame[code_at] = 8'(code);
                    code_at = wr;
                    wr++;
                    code = 1;
                end
                else
                begin
                    frame[wr] = payload[r];
                    wr++;
                    code++;
                end
            end
            frame[code_at] = 8'(code);
            frame[wr] = marker;
            wr++;
            for (int k = 0; k < wr; k++)
                push_beat(KIND_FRAME, frame[k], (k + 1 == wr));
        endfunction

        // values shown as kind/byte/last
        function void check_beat(logic [1:0] kind, logic [7:0] value, logic last);
            beat_t want;
            if (due_beats.size() == 0)
            begin
                errors++;
                $display("%0t mismatch expected none actual %0d/%02h/%0b",
                         $time, kind, value, last);
                return;
            end
            want = due_beats.pop_front();
            if (want.kind !== kind || want.value !== value || want.last !== last)
            begin
                errors++;
                $display("%0t mismatch expected %0d/%02h/%0b actual %0d/%02h/%0b",
                         $time, want.kind, want.value, want.last, kind, value, last);
            end
        endfunction

        // every beat still owed at the end is a mismatch of its own
        function void report_missing();
            beat_t want;
            while (due_beats.size() != 0)
            begin
                want = due_beats.pop_front();
                errors++;
                $display("%0t mismatch expected %0d/%02h/%0b actual none",
                         $time, want.kind, want.value, want.last);
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic       command;
    logic [7:0] log_id;
    logic [2:0] data_count;
    logic [7:0] data_byte_0;
    logic [7:0] data_byte_1;
    logic [7:0] data_byte_2;
    logic [7:0] data_byte_3;
    logic       cfg_we;
    logic [7:0] cfg_wdata;
    logic       result_valid;
    logic [1:0] result_kind;
    logic [7:0] frame_byte;
    logic       last_of_run;

    cobs_frame_board board;
    int              sender_idle;   // percent of cycles the sender holds back
    logic [7:0]      marker_now;    // marker the stimulus aims data bytes at
    int              quiet_cycles;

    log_packet_queue_cobs_framer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .log_id       (log_id),
        .data_count   (data_count),
        .data_byte_0  (data_byte_0),
        .data_byte_1  (data_byte_1),
        .data_byte_2  (data_byte_2),
        .data_byte_3  (data_byte_3),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .result_valid (result_valid),
        .result_kind  (result_kind),
        .frame_byte   (frame_byte),
        .last_of_run  (last_of_run)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // monitor: everything is sampled at the rising edge, before the block's
    // own updates land, so acceptance is noted ahead of any beat it causes
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                board.set_marker(cfg_wdata);
            if (start && !busy)
                board.note_command(command, log_id, data_count,
                                   {data_byte_3, data_byte_2, data_byte_1, data_byte_0});
            if (result_valid)
                board.check_beat(result_kind, frame_byte, last_of_run);
            // watchdog on a block that has stopped taking or giving beats
            if ((start && !busy) || result_valid || cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t watchdog expired, %0d beats outstanding", $time, board.pending());
                $display("status: fail");
                $finish;
            end
        end
    end

    // one command beat: optional idle gap, then hold start until busy is low
    task automatic send_command(logic cmd, logic [7:0] id, logic [2:0] cnt,
                                logic [7:0] b0, logic [7:0] b1,
                                logic [7:0] b2, logic [7:0] b3);
        int gap;
        gap = 0;
        while (gap < GAP_CAP && $urandom_range(99) < sender_idle)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        command     <= cmd;
        log_id      <= id;
        data_count  <= cnt;
        data_byte_0 <= b0;
        data_byte_1 <= b1;
        data_byte_2 <= b2;
        data_byte_3 <= b3;
        do
            @(posedge clk);
        while (busy);
    endtask

    // let every outstanding beat come back, then let the block settle
    task automatic drain();
        start <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    // marker change only with the block idle
    task automatic write_marker(logic [7:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        marker_now = v;
    endtask

    // data bytes lean towards the marker so groups are split often
    function automatic logic [7:0] pick_byte();
        if ($urandom_range(99) < 30)
            return marker_now;
        return 8'($urandom_range(255));
    endfunction

    // random burst; enq_pct steers the ring towards full or towards empty
    task automatic run_phase(int items, int idle_pct, int enq_pct);
        logic       cmd;
        logic [2:0] cnt;
        sender_idle = idle_pct;
        for (int n = 0; n < items; n++)
        begin
            cmd = ($urandom_range(99) < enq_pct) ? CMD_ENQUEUE : CMD_TRANSMIT;
            // mostly legal counts, now and then an oversized one
            cnt = ($urandom_range(9) < 8) ? 3'($urandom_range(4)) : 3'($urandom_range(7, 5));
            send_command(cmd, pick_byte(), cnt, pick_byte(), pick_byte(),
                         pick_byte(), pick_byte());
        end
    endtask

    initial
    begin
        board        = new();
        quiet_cycles = 0;
        sender_idle  = 0;
        marker_now   = MARKER_RESET;
        rst_n       <= 1'b0;
        start       <= 1'b0;
        command     <= CMD_ENQUEUE;
        log_id      <= 8'h00;
        data_count  <= 3'd0;
        data_byte_0 <= 8'h00;
        data_byte_1 <= 8'h00;
        data_byte_2 <= 8'h00;
        data_byte_3 <= 8'h00;
        cfg_we      <= 1'b0;
        cfg_wdata   <= 8'h00;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part under the reset marker 0xa6
        // transmit with nothing queued, enqueue fields carry junk
        send_command(CMD_TRANSMIT, 8'hFF, 3'd7, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        // id equal to the marker, no data
        send_command(CMD_ENQUEUE, 8'hA6, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00);
        // every data byte is the marker
        send_command(CMD_ENQUEUE, 8'h00, 3'd4, 8'hA6, 8'hA6, 8'hA6, 8'hA6);
        // oversized counts are clipped to four
        send_command(CMD_ENQUEUE, 8'hFF, 3'd7, 8'hFF, 8'h00, 8'hA6, 8'h55);
        send_command(CMD_ENQUEUE, 8'h12, 3'd5, 8'hA6, 8'h01, 8'h02, 8'h03);
        send_command(CMD_ENQUEUE, 8'hA6, 3'd6, 8'h11, 8'hA6, 8'h22, 8'hA6);
        // bytes beyond the count are ignored
        send_command(CMD_ENQUEUE, 8'h5A, 3'd3, 8'h01, 8'h02, 8'h03, 8'hFF);
        send_command(CMD_ENQUEUE, 8'h34, 3'd1, 8'hA6, 8'h00, 8'h00, 8'h00);
        repeat (7)
            send_command(CMD_TRANSMIT, 8'($urandom_range(255)), 3'($urandom_range(7)),
                         8'($urandom_range(255)), 8'($urandom_range(255)),
                         8'($urandom_range(255)), 8'($urandom_range(255)));
        // drained again
        send_command(CMD_TRANSMIT, 8'h00, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00);

        // random phases, each under its own marker and idling
        write_marker(8'h00);
        run_phase(26, 0, 80);    // fills the ring, drops on full
        write_marker(8'hFF);
        run_phase(26, 84, 20);   // empties it again
        // small marker: code bytes may equal it
        write_marker(8'($urandom_range(6, 1)));
        run_phase(26, 15, 60);
        write_marker(8'($urandom_range(255)));
        run_phase(26, 0, 45);

        drain();
        repeat (20) @(posedge clk);
        board.report_missing();
        if (board.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/lpqcf_pkg.sv
hw/rtl/lpqcf_ctrl.sv
hw/rtl/lpqcf_dpath.sv
hw/rtl/log_packet_queue_cobs_framer.sv
tb/tb_log_packet_queue_cobs_framer.sv
